FILE: rtl/core/gtp_pkg.sv
// Shared types, constants and tables for the go-to-pose controller core.
// Depends on nothing; every other file of the block imports it.
package gtp_pkg;

    // CORDIC configuration and pipeline depths
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
    localparam int PIPE_LAT     = CORDIC_STEPS + 11;

    // CORDIC data widths
    localparam int IW  = 34;   // input components
    localparam int CW  = 37;   // internal x/y
    localparam int AW  = 28;   // angle, Q.24 radians
    localparam int MW  = 36;   // magnitude
    localparam int SW  = 5;    // normalising shift

    localparam logic signed [AW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [28:0]   PI_Q24      = 29'sd52707179;
    localparam logic signed [28:0]   TWO_PI_Q24  = 29'sd105414357;
    localparam logic [29:0]          INV_GAIN_Q30   = 30'd652032874;
    localparam logic [15:0]          DRIVE_GAIN_Q16 = 16'd39322;
    localparam logic [13:0]          LIN_MAX        = 14'd8192;
    localparam logic signed [17:0]   TURN_FAR_MAX   = 18'sd24576;
    localparam logic signed [17:0]   TURN_NEAR_MAX  = 18'sd16384;

    localparam logic signed [AW-1:0] ATAN_TAB [8] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069
    };

    // arctangent of 2^-i in Q.24
    function automatic logic signed [AW-1:0] atan_entry(input int i);
        logic signed [AW-1:0] v;
        if (i < 8) begin
            v = ATAN_TAB[i[2:0]];
        end else begin
            v = AW'(1) << (24 - i);
        end
        return v;
    endfunction

    typedef enum logic [1:0] {
        ST_MOVING   = 2'd0,
        ST_REACHED  = 2'd1,
        ST_CANCELED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_GOAL_X    = 3'd0,
        CFG_GOAL_Y    = 3'd1,
        CFG_GOAL_HEAD = 3'd2,
        CFG_POS_TOL   = 3'd3,
        CFG_GATE      = 3'd4,
        CFG_ANG_TOL   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_pose_in;

    typedef struct packed {
        logic [13:0]        linear_speed;
        logic signed [15:0] turn_rate;
        logic [31:0]        distance;
        logic signed [15:0] bearing_err;
        logic signed [15:0] current_heading;
        t_status            status;
    } t_cmd_out;

    // CORDIC result as seen by the top level
    typedef struct packed {
        logic                 valid;
        logic signed [AW-1:0] angle;
        logic [MW-1:0]        mag;
        logic [SW-1:0]        shift;
    } t_cordic_res;

endpackage

FILE: rtl/core/gtp_cordic.sv
// Pipelined vectoring CORDIC: angle, raw magnitude and normalising shift.
// Depends on gtp_pkg; one iteration per register stage.
module gtp_cordic import gtp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [IW-1:0] i_x,
    input  logic signed [IW-1:0] i_y,
    output t_cordic_res          o_res
);

    logic                 r_c0_vld, r_c1_vld;
    logic signed [IW-1:0] r_c0_x, r_c0_y, r_c1_x, r_c1_y;
    logic [IW-1:0]        r_c0_m;
    logic [SW-1:0]        r_c1_s;
    logic                 r_c1_zero;

    logic                 r_it_vld  [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_it_x    [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_it_y    [0:CORDIC_STEPS];
    logic signed [AW-1:0] r_it_z    [0:CORDIC_STEPS];
    logic [SW-1:0]        r_it_s    [0:CORDIC_STEPS];
    logic                 r_it_zero [0:CORDIC_STEPS];

    logic [IW-1:0]        w_ax, w_ay;
    logic [SW-1:0]        w_s;
    logic signed [CW-1:0] w_xs, w_ys;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_vld    <= 1'b0;
            r_c1_vld    <= 1'b0;
            r_it_vld[0] <= 1'b0;
        end else begin
            r_c0_vld    <= i_valid;
            r_c1_vld    <= r_c0_vld;
            r_it_vld[0] <= r_c1_vld;
        end
    end

    // stage 0: larger absolute component
    assign w_ax = i_x[IW-1] ? IW'(-i_x) : IW'(i_x);
    assign w_ay = i_y[IW-1] ? IW'(-i_y) : IW'(i_y);

    always_ff @(posedge i_clk) begin
        r_c0_x <= i_x;
        r_c0_y <= i_y;
        r_c0_m <= (w_ax > w_ay) ? w_ax : w_ay;
    end

    // stage 1: shift that lifts the larger component to 2^31 or more
    always_comb begin
        w_s = '0;
        for (int b = 0; b < 31; b++) begin
            if (r_c0_m[b]) begin
                w_s = SW'(31 - b);
            end
        end
        if (r_c0_m[IW-1:31] != '0) begin
            w_s = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1_x    <= r_c0_x;
        r_c1_y    <= r_c0_y;
        r_c1_s    <= w_s;
        r_c1_zero <= (r_c0_m == '0);
    end

    // stage 2: normalise and pre-rotate by a quarter turn when x < 0
    assign w_xs = CW'(r_c1_x) <<< r_c1_s;
    assign w_ys = CW'(r_c1_y) <<< r_c1_s;

    always_ff @(posedge i_clk) begin
        r_it_s[0]    <= r_c1_s;
        r_it_zero[0] <= r_c1_zero;
        if (w_xs[CW-1]) begin
            if (!w_ys[CW-1]) begin
                r_it_x[0] <= w_ys;
                r_it_y[0] <= -w_xs;
                r_it_z[0] <= HALF_PI_Q24;
            end else begin
                r_it_x[0] <= -w_ys;
                r_it_y[0] <= w_xs;
                r_it_z[0] <= -HALF_PI_Q24;
            end
        end else begin
            r_it_x[0] <= w_xs;
            r_it_y[0] <= w_ys;
            r_it_z[0] <= '0;
        end
    end

    // micro-rotation stages
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_it_vld[k+1] <= 1'b0;
            end else begin
                r_it_vld[k+1] <= r_it_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_it_s[k+1]    <= r_it_s[k];
            r_it_zero[k+1] <= r_it_zero[k];
            if (!r_it_y[k][CW-1]) begin
                r_it_x[k+1] <= r_it_x[k] + (r_it_y[k] >>> k);
                r_it_y[k+1] <= r_it_y[k] - (r_it_x[k] >>> k);
                r_it_z[k+1] <= r_it_z[k] + atan_entry(k);
            end else begin
                r_it_x[k+1] <= r_it_x[k] - (r_it_y[k] >>> k);
                r_it_y[k+1] <= r_it_y[k] + (r_it_x[k] >>> k);
                r_it_z[k+1] <= r_it_z[k] - atan_entry(k);
            end
        end
    end

    // a zero vector reads as angle 0, magnitude 0
    always_comb begin
        o_res.valid = r_it_vld[CORDIC_STEPS];
        if (r_it_zero[CORDIC_STEPS]) begin
            o_res.angle = '0;
            o_res.mag   = '0;
            o_res.shift = '0;
        end else begin
            o_res.angle = r_it_z[CORDIC_STEPS];
            o_res.mag   = r_it_x[CORDIC_STEPS][MW-1:0];
            o_res.shift = r_it_s[CORDIC_STEPS];
        end
    end

endmodule

FILE: rtl/core/go_to_pose_controller_core.sv
// Top level of the go-to-pose controller: goal registers, pose pipeline, command output.
// Depends on gtp_pkg and gtp_cordic.

// One item (pose sample or cancel) is taken in every clock cycle; o_busy stays low.
// Each item gives exactly one result, strobed by o_done for one cycle, after stages 1
// and 2, the two parallel CORDIC pipelines of one stage per iteration, the distance
// scaling and decision stages 3 to 7 and the output register. Results come out in
// order and cannot be held off.
// Goal and tolerance registers are written through the plain write port and should
// only change while no item is in flight.
module go_to_pose_controller_core import gtp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_pose_in    i_cmd,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_done,
    output t_cmd_out    o_result
);

    // configuration registers
    logic signed [31:0] r_goal_x, r_goal_y;
    logic signed [15:0] r_goal_head;
    logic [30:0]        r_pos_tol;
    logic [14:0]        r_gate, r_ang_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_goal_head <= '0;
            r_pos_tol   <= 31'd6554;
            r_gate      <= 15'd2867;
            r_ang_tol   <= 15'd410;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GOAL_X:    r_goal_x    <= i_cfg_wdata;
                CFG_GOAL_Y:    r_goal_y    <= i_cfg_wdata;
                CFG_GOAL_HEAD: r_goal_head <= i_cfg_wdata[15:0];
                CFG_POS_TOL:   r_pos_tol   <= i_cfg_wdata[30:0];
                CFG_GATE:      r_gate      <= i_cfg_wdata[14:0];
                CFG_ANG_TOL:   r_ang_tol   <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [28:0] wrap_ang(input logic signed [28:0] a);
        logic signed [28:0] v;
        v = a;
        if (v > PI_Q24) begin
            v = v - TWO_PI_Q24;
        end
        if (v < -PI_Q24) begin
            v = v + TWO_PI_Q24;
        end
        return v;
    endfunction

    function automatic logic signed [15:0] to_q13(input logic signed [28:0] a);
        logic signed [28:0] v;
        v = (a + 29'sd1024) >>> 11;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] clamp4(input logic signed [15:0] a,
                                                  input logic signed [17:0] lim);
        logic signed [17:0] v;
        v = $signed({a, 2'b00});
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] abs16(input logic signed [15:0] a);
        return a[15] ? 16'(-a) : 16'(a);
    endfunction

    logic w_accept;
    assign o_busy   = 1'b0;
    assign w_accept = i_start & ~o_busy;

    // stage 1: offsets to goal and quaternion products
    logic               r1_vld, r1_mode;
    logic signed [32:0] r1_dx, r1_dy;
    logic signed [31:0] r1_pwz, r1_pxy, r1_pyy, r1_pzz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mode <= i_cmd.mode;
        r1_dx   <= 33'(r_goal_x) - 33'($signed(i_cmd.pos_x));
        r1_dy   <= 33'(r_goal_y) - 33'($signed(i_cmd.pos_y));
        r1_pwz  <= $signed(i_cmd.quat_w) * $signed(i_cmd.quat_z);
        r1_pxy  <= $signed(i_cmd.quat_x) * $signed(i_cmd.quat_y);
        r1_pyy  <= $signed(i_cmd.quat_y) * $signed(i_cmd.quat_y);
        r1_pzz  <= $signed(i_cmd.quat_z) * $signed(i_cmd.quat_z);
    end

    // stage 2: yaw vector in Q2.28
    logic                 r2_vld, r2_mode;
    logic signed [IW-1:0] r2_num, r2_den, r2_dx, r2_dy;
    logic signed [32:0]   w_wzxy, w_sq;

    assign w_wzxy = 33'(r1_pwz) + 33'(r1_pxy);
    assign w_sq   = 33'(r1_pyy) + 33'(r1_pzz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_mode <= r1_mode;
        r2_num  <= $signed({w_wzxy, 1'b0});
        r2_den  <= 34'sh10000000 - $signed({w_sq, 1'b0});
        r2_dx   <= IW'(r1_dx);
        r2_dy   <= IW'(r1_dy);
    end

    // yaw and bearing CORDICs run side by side
    t_cordic_res w_yaw_res, w_bear_res;

    gtp_cordic u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_x     (r2_den),
        .i_y     (r2_num),
        .o_res   (w_yaw_res)
    );

    gtp_cordic u_bear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_x     (r2_dx),
        .i_y     (r2_dy),
        .o_res   (w_bear_res)
    );

    // mode bit follows the CORDIC latency
    logic r_mode_dly [0:CORDIC_LAT-1];

    always_ff @(posedge i_clk) begin
        r_mode_dly[0] <= r2_mode;
        for (int k = 1; k < CORDIC_LAT; k++) begin
            r_mode_dly[k] <= r_mode_dly[k-1];
        end
    end

    // stage 3: wrap yaw, partial products of the magnitude scaling
    logic               r3_vld, r3_mode;
    logic signed [28:0] r3_yaw, r3_bear;
    logic [47:0]        r3_plo, r3_phi;
    logic [SW-1:0]      r3_s;

    always_ff @(posedge i_clk) begin
        r3_mode <= r_mode_dly[CORDIC_LAT-1];
        r3_yaw  <= wrap_ang(29'(w_yaw_res.angle));
        r3_bear <= 29'(w_bear_res.angle);
        r3_plo  <= 48'(w_bear_res.mag[17:0]) * 48'(INV_GAIN_Q30);
        r3_phi  <= 48'(w_bear_res.mag[MW-1:18]) * 48'(INV_GAIN_Q30);
        r3_s    <= w_bear_res.shift;
    end

    // stage 4: raw angle differences, full scaled magnitude
    logic               r4_vld, r4_mode;
    logic signed [28:0] r4_herr, r4_ferr, r4_yaw;
    logic [65:0]        r4_prod;
    logic [SW-1:0]      r4_s;

    always_ff @(posedge i_clk) begin
        r4_mode <= r3_mode;
        r4_herr <= r3_bear - r3_yaw;
        r4_ferr <= 29'($signed({r_goal_head, 11'b0})) - r3_yaw;
        r4_yaw  <= r3_yaw;
        r4_prod <= {r3_phi, 18'b0} + 66'(r3_plo);
        r4_s    <= r3_s;
    end

    // stage 5: wrap and round angles, coarse distance shift
    logic               r5_vld, r5_mode;
    logic signed [15:0] r5_herr, r5_ferr, r5_yaw;
    logic [36:0]        r5_prod_sh;
    logic [5:0]         w_sh;

    assign w_sh = 6'd29 + 6'(r4_s);

    always_ff @(posedge i_clk) begin
        r5_mode    <= r4_mode;
        r5_herr    <= to_q13(wrap_ang(r4_herr));
        r5_ferr    <= to_q13(wrap_ang(r4_ferr));
        r5_yaw     <= to_q13(r4_yaw);
        r5_prod_sh <= 37'(r4_prod >> w_sh);
    end

    // stage 6: round and saturate distance, absolute errors
    logic               r6_vld, r6_mode;
    logic signed [15:0] r6_herr, r6_ferr, r6_yaw;
    logic [15:0]        r6_abs_h, r6_abs_f;
    logic [31:0]        r6_dist;
    logic [37:0]        w_rnd;

    assign w_rnd = 38'(r5_prod_sh) + 38'd1;

    always_ff @(posedge i_clk) begin
        r6_mode  <= r5_mode;
        r6_herr  <= r5_herr;
        r6_ferr  <= r5_ferr;
        r6_yaw   <= r5_yaw;
        r6_abs_h <= abs16(r5_herr);
        r6_abs_f <= abs16(r5_ferr);
        r6_dist  <= (w_rnd[37:33] != '0) ? 32'hFFFF_FFFF : w_rnd[32:1];
    end

    // stage 7: drive product, comparisons, clamped turn rates
    logic               r7_vld, r7_mode, r7_far, r7_gate_ok, r7_ang_far;
    logic signed [15:0] r7_herr, r7_yaw, r7_turn_far, r7_turn_near;
    logic [31:0]        r7_dist;
    logic [47:0]        r7_lin_prod;

    always_ff @(posedge i_clk) begin
        r7_mode      <= r6_mode;
        r7_herr      <= r6_herr;
        r7_yaw       <= r6_yaw;
        r7_dist      <= r6_dist;
        r7_lin_prod  <= 48'(r6_dist) * 48'(DRIVE_GAIN_Q16);
        r7_far       <= r6_dist > {1'b0, r_pos_tol};
        r7_gate_ok   <= r6_abs_h < {1'b0, r_gate};
        r7_ang_far   <= r6_abs_f > {1'b0, r_ang_tol};
        r7_turn_far  <= clamp4(r6_herr, TURN_FAR_MAX);
        r7_turn_near <= clamp4(r6_ferr, TURN_NEAR_MAX);
    end

    // valid bits of stages 3 to 7
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else begin
            r3_vld <= w_bear_res.valid;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    // output stage: command selection
    logic [30:0] w_lin_v;
    logic [13:0] w_lin;
    t_cmd_out    n_result;
    t_cmd_out    r_result;
    logic        r_done;

    assign w_lin_v = 31'((r7_lin_prod + 48'd131072) >> 18);
    assign w_lin   = (w_lin_v > 31'(LIN_MAX)) ? LIN_MAX : w_lin_v[13:0];

    always_comb begin
        n_result.linear_speed    = '0;
        n_result.turn_rate       = '0;
        n_result.distance        = r7_dist;
        n_result.bearing_err     = r7_herr;
        n_result.current_heading = r7_yaw;
        n_result.status          = ST_MOVING;
        priority if (r7_mode) begin
            n_result.distance        = '0;
            n_result.bearing_err     = '0;
            n_result.current_heading = '0;
            n_result.status          = ST_CANCELED;
        end else if (r7_far) begin
            n_result.turn_rate = r7_turn_far;
            if (r7_gate_ok) begin
                n_result.linear_speed = w_lin;
            end
        end else if (r7_ang_far) begin
            n_result.turn_rate = r7_turn_near;
        end else begin
            n_result.status = ST_REACHED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: rtl/core/gtp_checker.sv
// Port-level checks for the go-to-pose controller core, bound to the top level.
// Depends on gtp_pkg.
module gtp_checker import gtp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input t_pose_in    i_cmd,
    input logic        o_done,
    input t_cmd_out    o_result
);

    // every result goes back to an item taken a fixed time earlier
    a_done_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, PIPE_LAT))
        else $error("result without an item");

    // a cancel comes out as a cancel
    a_cancel_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd.mode) |-> ##PIPE_LAT
        (o_done && o_result.status == ST_CANCELED))
        else $error("cancel item lost");

    // a pose sample never reports canceled
    a_pose_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_cmd.mode) |-> ##PIPE_LAT
        (o_done && o_result.status != ST_CANCELED))
        else $error("pose item lost or misreported");

    // stopped results carry no motion
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_MOVING) |->
        (o_result.linear_speed == '0 && o_result.turn_rate == '0))
        else $error("motion on a stop result");

endmodule

bind go_to_pose_controller_core gtp_checker u_gtp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_cmd    (i_cmd),
    .o_done   (o_done),
    .o_result (o_result)
);

FILE: tb/tb_go_to_pose_controller_core.sv
// Testbench for go_to_pose_controller_core: directed and random pose samples and cancels
// over several goal/tolerance settings, each result checked against a local predictor.
// Depends on gtp_pkg and the go_to_pose_controller_core RTL.
`timescale 1ns / 1ps

module tb_go_to_pose_controller_core;
    import gtp_pkg::*;

    localparam logic [2:0] CFG_SPARE_A = 3'd6;   // unmapped register indexes
    localparam logic [2:0] CFG_SPARE_B = 3'd7;
    localparam int         STALL_LIMIT = 4000;
    localparam longint     PI_RAD24    = 52707179;
    localparam longint     TWO_PI_RAD24 = 105414357;
    localparam longint     QUARTER_RAD24 = 26353589;
    localparam longint     ATAN_Q24 [8] = '{13176795, 7778716, 4110060, 2086331,
                                            1047214, 524117, 262123, 131069};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_pose_in    i_cmd = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_done;
    t_cmd_out    o_result;

    // local copy of the goal and tolerance registers
    logic signed [31:0] goal_x = 0;
    logic signed [31:0] goal_y = 0;
    logic signed [15:0] goal_head = 0;
    logic [30:0]        pos_tol = 31'd6554;
    logic [14:0]        gate = 15'd2867;
    logic [14:0]        ang_tol = 15'd410;

    t_cmd_out cmd_pending [$];
    int       mismatches = 0;
    int       items_sent = 0;
    int       results_seen = 0;
    int       reached_seen = 0;
    int       cancels_seen = 0;
    int       idle_cycles = 0;
    bit       item_taken = 0;

    go_to_pose_controller_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // vectoring rotation: angle in Q.24, scaled magnitude and normalising shift
    function automatic void vector_angle(input longint vx, input longint vy,
                                         output longint ang, output longint unsigned mag,
                                         output int sh);
        longint x, y, z, t, xs, ys, step;
        longint unsigned m, ax, ay;
        x = vx;
        y = vy;
        z = 0;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        sh = 0;
        mag = 0;
        ang = 0;
        if (m == 0) return;
        while (m < (64'd1 << 31)) begin
            m = m << 1;
            sh++;
        end
        x = x <<< sh;
        y = y <<< sh;
        // quarter-turn pre-rotation into the right half plane
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = QUARTER_RAD24;
            end else begin
                x = -y; y = t; z = -QUARTER_RAD24;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            step = (i < 8) ? ATAN_Q24[i] : (64'sd1 <<< (24 - i));
            if (y >= 0) begin
                x += ys; y -= xs; z += step;
            end else begin
                x -= ys; y += xs; z -= step;
            end
        end
        mag = x;
        ang = z;
    endfunction

    function automatic longint wrap_angle(input longint a);
        longint r;
        r = a;
        if (r > PI_RAD24) r -= TWO_PI_RAD24;
        if (r < -PI_RAD24) r += TWO_PI_RAD24;
        return r;
    endfunction

    function automatic longint round_q13(input longint a);
        return (a + 1024) >>> 11;
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        return (v < -lim) ? -lim : ((v > lim) ? lim : v);
    endfunction

    // expected command for one pose sample or cancel under the current settings
    function automatic t_cmd_out predict_command(input t_pose_in p);
        t_cmd_out r;
        longint num, den, yaw, bear, herr, ferr, aerr, dummy_a, lin, turn, yaw13;
        longint unsigned mag, dist_q16, prod, dm;
        int sh, dsh;
        r = '0;
        if (p.mode) begin
            r.status = ST_CANCELED;
            return r;
        end
        num = 2 * (longint'(p.quat_w) * p.quat_z + longint'(p.quat_x) * p.quat_y);
        den = (64'sd1 <<< 28) - 2 * (longint'(p.quat_y) * p.quat_y
                                     + longint'(p.quat_z) * p.quat_z);
        vector_angle(den, num, dummy_a, dm, dsh);
        yaw = wrap_angle(dummy_a);
        vector_angle(longint'(goal_x) - p.pos_x, longint'(goal_y) - p.pos_y, bear, mag, sh);
        prod = mag * 64'd652032874;
        dist_q16 = (prod + (64'd1 << (29 + sh))) >> (30 + sh);
        if (dist_q16 > 64'hFFFF_FFFF) dist_q16 = 64'hFFFF_FFFF;
        herr = round_q13(wrap_angle(bear - yaw));
        ferr = round_q13(wrap_angle(longint'(goal_head) * 2048 - yaw));
        yaw13 = round_q13(yaw);
        lin = 0;
        turn = 0;
        if (dist_q16 > pos_tol) begin
            r.status = ST_MOVING;
            turn = clamp(herr * 4, 24576);
            aerr = (herr < 0) ? -herr : herr;
            if (aerr < gate) begin
                lin = (dist_q16 * 39322 + (64'd1 << 17)) >> 18;
                if (lin > 8192) lin = 8192;
            end
        end else begin
            aerr = (ferr < 0) ? -ferr : ferr;
            if (aerr > ang_tol) begin
                r.status = ST_MOVING;
                turn = clamp(ferr * 4, 16384);
            end else begin
                r.status = ST_REACHED;
            end
        end
        r.linear_speed = lin[13:0];
        r.turn_rate = turn[15:0];
        r.distance = dist_q16[31:0];
        r.bearing_err = herr[15:0];
        r.current_heading = yaw13[15:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH result %0d %s: expected %0h got %0h",
                         results_seen, name, want, got);
        end
    endfunction

    // result checker: compares each strobed command with the oldest expectation
    always @(posedge i_clk) begin
        t_cmd_out want;
        if (i_rst_n && o_done) begin
            if (cmd_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("MISMATCH unexpected result %p", o_result);
            end else begin
                want = cmd_pending.pop_front();
                check_field("linear_speed", want.linear_speed, o_result.linear_speed);
                check_field("turn_rate", want.turn_rate, o_result.turn_rate);
                check_field("distance", want.distance, o_result.distance);
                check_field("bearing_err", want.bearing_err, o_result.bearing_err);
                check_field("current_heading", want.current_heading,
                            o_result.current_heading);
                check_field("status", want.status, o_result.status);
                if (want.status == ST_REACHED) reached_seen++;
                if (want.status == ST_CANCELED) cancels_seen++;
            end
            results_seen++;
        end
    end

    // watchdog: cycles in which neither side moves an item
    always @(posedge i_clk) begin
        if ((i_rst_n && o_done) || item_taken) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // send one item; start stays high so back-to-back items need no gap
    task automatic send_item(input t_pose_in p);
        i_start <= 1'b1;
        i_cmd <= p;
        do @(posedge i_clk); while (o_busy);
        item_taken = 1;
        cmd_pending.push_back(predict_command(p));
        items_sent++;
    endtask

    task automatic pause(input int n);
        i_start <= 1'b0;
        item_taken = 0;
        repeat (n) @(posedge i_clk);
    endtask

    // let the pipeline drain before registers are written back to back
    task automatic drain;
        pause(1);
        while (cmd_pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_GOAL_X:    goal_x = val;
            CFG_GOAL_Y:    goal_y = val;
            CFG_GOAL_HEAD: goal_head = val[15:0];
            CFG_POS_TOL:   pos_tol = val[30:0];
            CFG_GATE:      gate = val[14:0];
            CFG_ANG_TOL:   ang_tol = val[14:0];
            default: ;
        endcase
    endtask

    task automatic end_writes;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_pose_in make_pose(input bit cancel, input longint px, input longint py,
                                           input int qx, input int qy, input int qz,
                                           input int qw);
        t_pose_in p;
        p.mode = cancel;
        p.pos_x = px[31:0];
        p.pos_y = py[31:0];
        p.quat_x = qx[15:0];
        p.quat_y = qy[15:0];
        p.quat_z = qz[15:0];
        p.quat_w = qw[15:0];
        return p;
    endfunction

    // random item: mostly poses around the goal at spread distances
    function automatic t_pose_in random_pose;
        t_pose_in p;
        int k;
        k = $urandom_range(0, 99);
        p = 129'({$urandom, $urandom, $urandom, $urandom, $urandom});
        p.mode = (k < 8);
        if (k >= 20) begin
            p.pos_x = goal_x + ($signed($urandom) >>> $urandom_range(0, 31));
            p.pos_y = goal_y + ($signed($urandom) >>> $urandom_range(0, 31));
        end
        if (k >= 15 && k < 60) begin
            p.quat_x = 16'($signed($urandom) >>> $urandom_range(2, 15));
            p.quat_y = 16'($signed($urandom) >>> $urandom_range(2, 15));
            p.quat_z = 16'($urandom_range(0, 32768) - 16384);
            p.quat_w = 16'($urandom_range(0, 32768) - 16384);
        end else if (k >= 60 && k < 75) begin
            // level yaw-only orientation, often close to the goal
            p.quat_x = 0;
            p.quat_y = 0;
            p.quat_z = 16'($signed($urandom) >>> $urandom_range(3, 16));
            p.quat_w = 16384;
            if ($urandom_range(0, 1)) begin
                p.pos_x = goal_x + ($signed($urandom) >>> $urandom_range(17, 31));
                p.pos_y = goal_y + ($signed($urandom) >>> $urandom_range(17, 31));
            end
        end
        return p;
    endfunction

    // bursts of random length, random gaps, some long unbroken stretches
    task automatic run_random(input int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 25);
            if (burst > left) burst = left;
            repeat (burst) send_item(random_pose());
            left -= burst;
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
        end
    endtask

    task automatic test_directed;
        // cancels, with all other fields set and clear
        send_item(make_pose(1, 0, 0, 0, 0, 0, 16384));
        send_item(make_pose(1, -1, -1, -1, -1, -1, -1));
        // at the goal: zero distance, reached, and a zero yaw vector
        send_item(make_pose(0, 0, 0, 0, 0, 0, 16384));
        send_item(make_pose(0, 0, 0, 0, 8192, 8192, 0));
        send_item(make_pose(0, 0, 0, 0, 0, 0, 0));
        // near the goal, turning on the spot both ways
        send_item(make_pose(0, 100, -100, 0, 0, 6000, 15000));
        send_item(make_pose(0, -100, 100, 0, 0, -6000, 15000));
        // far away, inside and outside the gate, and behind
        send_item(make_pose(0, -65536, 0, 0, 0, 0, 16384));
        send_item(make_pose(0, 65536, 0, 0, 0, 0, 16384));
        send_item(make_pose(0, 30000, 40000, 0, 0, 16384, 0));
        send_item(make_pose(0, 30000, -40000, 0, 0, -11585, 11585));
        send_item(make_pose(0, -655360, 1, 0, 0, 11585, 11585));
        // field extremes, including out-of-range quaternion parts
        send_item(make_pose(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16384, 16384, 16384, 16384));
        send_item(make_pose(0, -2147483648, -2147483648, -16384, -16384, -16384, -16384));
        send_item(make_pose(0, -2147483648, 32'h7FFF_FFFF, -32768, 32767, -32768, 32767));
        send_item(make_pose(0, 32'h7FFF_FFFF, -2147483648, 32767, -32768, 32767, -32768));
        send_item(make_pose(0, 1, 0, 0, 0, 0, 16384));
        send_item(make_pose(0, 0, -1, 0, 0, 0, -16384));
    endtask

    task automatic test_default_goal;
        run_random(400);
    endtask

    task automatic test_far_goal;
        drain();
        write_reg(CFG_GOAL_X, 32'h7FFF_FFFF);
        write_reg(CFG_GOAL_Y, 32'h8000_0000);
        write_reg(CFG_GOAL_HEAD, 32'd25736);
        write_reg(CFG_POS_TOL, 32'h7FFF_FFFF);
        write_reg(CFG_GATE, 32'd25736);
        write_reg(CFG_ANG_TOL, 32'd0);
        end_writes();
        send_item(make_pose(0, -2147483648, 32'h7FFF_FFFF, 0, 0, 0, 16384));
        send_item(make_pose(0, 32'h7FFF_FFFF, -2147483648, 0, 0, 0, 16384));
        run_random(300);
    endtask

    task automatic test_tight_tolerances;
        drain();
        write_reg(CFG_GOAL_X, 32'h8000_0000);
        write_reg(CFG_GOAL_Y, 32'h7FFF_FFFF);
        write_reg(CFG_GOAL_HEAD, -32'sd25736);
        write_reg(CFG_POS_TOL, 32'd0);
        write_reg(CFG_GATE, 32'd0);
        write_reg(CFG_ANG_TOL, 32'd25736);
        end_writes();
        run_random(300);
    endtask

    task automatic test_wide_gate;
        drain();
        write_reg(CFG_GOAL_X, 32'd327680);
        write_reg(CFG_GOAL_Y, -32'sd131072);
        write_reg(CFG_GOAL_HEAD, 32'd6434);
        write_reg(CFG_POS_TOL, 32'd65536);
        write_reg(CFG_GATE, 32'h7FFF);
        write_reg(CFG_ANG_TOL, 32'h7FFF);
        // unmapped indexes must leave the registers alone
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'h0);
        end_writes();
        run_random(300);
    endtask

    task automatic test_random_settings;
        repeat (3) begin
            drain();
            write_reg(CFG_GOAL_X, $urandom);
            write_reg(CFG_GOAL_Y, $urandom);
            write_reg(CFG_GOAL_HEAD, $urandom_range(0, 51472) - 25736);
            write_reg(CFG_POS_TOL, $urandom >> $urandom_range(1, 24));
            write_reg(CFG_GATE, $urandom_range(0, 25736));
            write_reg(CFG_ANG_TOL, $urandom_range(0, 4000));
            end_writes();
            run_random(150);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_default_goal();
        test_far_goal();
        test_tight_tolerances();
        test_wide_gate();
        test_random_settings();
        // wait out the pipeline, then a few spare cycles for strays
        pause(1);
        while (cmd_pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
        $display("Sent %0d items over several goal settings; %0d results checked,",
                 items_sent, results_seen);
        $display("%0d of them goal-reached and %0d cancels; %0d mismatches",
                 reached_seen, cancels_seen, mismatches);
        if (mismatches == 0 && cmd_pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
